FILE: sv/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared defaults for the ray / wall segment intersection pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    // Coordinate format, signed Q16.16 by default
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Register stages outside the divider (cross product 4, interpolation 3)
    // plus the divider's range check stage
    localparam int FIXED_STAGES = 8;

endpackage

`default_nettype wire

FILE: sv/rsi_cross.sv
// ----------------------------------------------------------------------------
// rsi_cross
// Edge differences, cross products, determinant and numerators, hit
// qualification and magnitudes. Four register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_cross #(
    parameter int CW = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [CW-1:0] i_origin_x,
    input  wire logic signed [CW-1:0] i_origin_y,
    input  wire logic signed [CW-1:0] i_ray_dx,
    input  wire logic signed [CW-1:0] i_ray_dy,
    input  wire logic signed [CW-1:0] i_wall_start_x,
    input  wire logic signed [CW-1:0] i_wall_start_y,
    input  wire logic signed [CW-1:0] i_wall_end_x,
    input  wire logic signed [CW-1:0] i_wall_end_y,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_ok,
    output logic [2*CW:0]             o_dm,
    output logic [2*CW:0]             o_tm,
    output logic signed [CW-1:0]      o_sx,
    output logic signed [CW-1:0]      o_sy,
    output logic signed [CW:0]        o_wx,
    output logic signed [CW:0]        o_wy
);
    import rsi_pkg::*;

    localparam int DW = CW + 1;      // differences
    localparam int PW = 2 * CW + 2;  // products
    localparam int SW = 2 * CW + 3;  // sums of products
    localparam int MW = 2 * CW + 1;  // magnitudes

    logic [4:1] r_v;
    logic [5:1] w_en;

    // stage 1
    logic signed [DW-1:0] r_wx1, r_wy1, r_gx1, r_gy1, r_ax1, r_ay1;
    logic signed [CW-1:0] r_sx1, r_sy1;
    // stage 2
    logic signed [PW-1:0] r_p_wyax, r_p_wxay, r_p_gyax, r_p_gxay, r_p_wygx, r_p_wxgy;
    logic signed [DW-1:0] r_wx2, r_wy2;
    logic signed [CW-1:0] r_sx2, r_sy2;
    // stage 3
    logic signed [SW-1:0] r_d, r_tn, r_un;
    logic signed [DW-1:0] r_wx3, r_wy3;
    logic signed [CW-1:0] r_sx3, r_sy3;
    // stage 4
    logic                 r_ok;
    logic [MW-1:0]        r_dm, r_tm;
    logic signed [DW-1:0] r_wx4, r_wy4;
    logic signed [CW-1:0] r_sx4, r_sy4;

    logic                 n_ok;
    logic [SW-1:0]        n_dabs, n_tabs;

    // a stage moves when it is empty or the one after it moves
    assign w_en[5] = i_ready;
    genvar g;
    generate
        for (g = 1; g <= 4; g++) begin : g_en
            assign w_en[g] = !r_v[g] || w_en[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_valid;
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
            if (w_en[4]) r_v[4] <= r_v[3];
        end
    end

    // stage 1: wall edge W = S - E and G = S - P, all exact at CW+1 bits
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_wx1 <= $signed({i_wall_start_x[CW-1], i_wall_start_x})
                   - $signed({i_wall_end_x[CW-1], i_wall_end_x});
            r_wy1 <= $signed({i_wall_start_y[CW-1], i_wall_start_y})
                   - $signed({i_wall_end_y[CW-1], i_wall_end_y});
            r_gx1 <= $signed({i_wall_start_x[CW-1], i_wall_start_x})
                   - $signed({i_origin_x[CW-1], i_origin_x});
            r_gy1 <= $signed({i_wall_start_y[CW-1], i_wall_start_y})
                   - $signed({i_origin_y[CW-1], i_origin_y});
            r_ax1 <= $signed({i_ray_dx[CW-1], i_ray_dx});
            r_ay1 <= $signed({i_ray_dy[CW-1], i_ray_dy});
            r_sx1 <= i_wall_start_x;
            r_sy1 <= i_wall_start_y;
        end
    end

    // stage 2: six products, one multiplier each
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_p_wyax <= r_wy1 * r_ax1;
            r_p_wxay <= r_wx1 * r_ay1;
            r_p_gyax <= r_gy1 * r_ax1;
            r_p_gxay <= r_gx1 * r_ay1;
            r_p_wygx <= r_wy1 * r_gx1;
            r_p_wxgy <= r_wx1 * r_gy1;
            r_wx2    <= r_wx1;
            r_wy2    <= r_wy1;
            r_sx2    <= r_sx1;
            r_sy2    <= r_sy1;
        end
    end

    // stage 3: determinant and numerators
    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_d   <= $signed({r_p_wyax[PW-1], r_p_wyax}) - $signed({r_p_wxay[PW-1], r_p_wxay});
            r_tn  <= $signed({r_p_gyax[PW-1], r_p_gyax}) - $signed({r_p_gxay[PW-1], r_p_gxay});
            r_un  <= $signed({r_p_wygx[PW-1], r_p_wygx}) - $signed({r_p_wxgy[PW-1], r_p_wxgy});
            r_wx3 <= r_wx2;
            r_wy3 <= r_wy2;
            r_sx3 <= r_sx2;
            r_sy3 <= r_sy2;
        end
    end

    // stage 4: both parameters must be nonzero with the sign of d
    always_comb begin
        n_ok = (r_d != '0) && (r_tn != '0) && (r_un != '0)
            && (r_tn[SW-1] == r_d[SW-1]) && (r_un[SW-1] == r_d[SW-1]);
        n_dabs = r_d[SW-1] ? (~r_d + 1'b1) : r_d;
        n_tabs = r_tn[SW-1] ? (~r_tn + 1'b1) : r_tn;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_ok  <= n_ok;
            r_dm  <= n_dabs[MW-1:0];
            r_tm  <= n_tabs[MW-1:0];
            r_wx4 <= r_wx3;
            r_wy4 <= r_wy3;
            r_sx4 <= r_sx3;
            r_sy4 <= r_sy3;
        end
    end

    assign o_ready = w_en[1];
    assign o_valid = r_v[4];
    assign o_ok    = r_ok;
    assign o_dm    = r_dm;
    assign o_tm    = r_tm;
    assign o_sx    = r_sx4;
    assign o_sy    = r_sy4;
    assign o_wx    = r_wx4;
    assign o_wy    = r_wy4;

endmodule

`default_nettype wire

FILE: sv/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// Restoring divider for t = |tn| / |d|, one quotient bit per stage, after a
// stage that rejects t >= 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_div #(
    parameter int CW = 32,
    parameter int FW = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_ok,
    input  wire logic [2*CW:0]        i_dm,
    input  wire logic [2*CW:0]        i_tm,
    input  wire logic signed [CW-1:0] i_sx,
    input  wire logic signed [CW-1:0] i_sy,
    input  wire logic signed [CW:0]   i_wx,
    input  wire logic signed [CW:0]   i_wy,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_ok,
    output logic [FW-1:0]             o_tq,
    output logic signed [CW-1:0]      o_sx,
    output logic signed [CW-1:0]      o_sy,
    output logic signed [CW:0]        o_wx,
    output logic signed [CW:0]        o_wy
);
    import rsi_pkg::*;

    localparam int MW = 2 * CW + 1;

    logic [FW:0]   r_v;
    logic [FW+1:0] w_en;

    logic                 r_ok  [0:FW];
    logic signed [CW-1:0] r_sx  [0:FW];
    logic signed [CW-1:0] r_sy  [0:FW];
    logic signed [CW:0]   r_wx  [0:FW];
    logic signed [CW:0]   r_wy  [0:FW];
    logic [MW-1:0]        r_rem [0:FW-1];
    logic [MW-1:0]        r_dm  [0:FW-1];
    logic [FW-1:0]        r_tq  [1:FW];

    assign w_en[FW+1] = i_ready;

    genvar k;
    generate
        for (k = 0; k <= FW; k++) begin : g_en
            assign w_en[k] = !r_v[k] || w_en[k+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_valid;
            for (int s = 1; s <= FW; s++) begin
                if (w_en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    // range check: the quotient must stay below one
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_ok[0]  <= i_ok && (i_tm < i_dm);
            r_rem[0] <= i_tm;
            r_dm[0]  <= i_dm;
            r_sx[0]  <= i_sx;
            r_sy[0]  <= i_sy;
            r_wx[0]  <= i_wx;
            r_wy[0]  <= i_wy;
        end
    end

    generate
        for (k = 1; k <= FW; k++) begin : g_step
            logic [MW:0]   w_sh;
            logic [MW:0]   w_dif;
            logic          w_ge;
            logic [FW-1:0] w_tq_prev;

            assign w_sh  = {r_rem[k-1], 1'b0};
            assign w_dif = w_sh - {1'b0, r_dm[k-1]};
            assign w_ge  = (w_sh >= {1'b0, r_dm[k-1]});

            if (k == 1) begin : g_first
                assign w_tq_prev = '0;
            end else begin : g_next
                assign w_tq_prev = r_tq[k-1];
            end

            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_tq[k] <= {w_tq_prev[FW-2:0], w_ge};
                    r_ok[k] <= r_ok[k-1];
                    r_sx[k] <= r_sx[k-1];
                    r_sy[k] <= r_sy[k-1];
                    r_wx[k] <= r_wx[k-1];
                    r_wy[k] <= r_wy[k-1];
                end
            end

            // remainder stays below the divisor for items in range, so MW bits hold it
            if (k < FW) begin : g_rem
                always_ff @(posedge i_clk) begin
                    if (w_en[k]) begin
                        r_rem[k] <= w_ge ? w_dif[MW-1:0] : w_sh[MW-1:0];
                        r_dm[k]  <= r_dm[k-1];
                    end
                end
            end
        end
    endgenerate

    assign o_ready = w_en[0];
    assign o_valid = r_v[FW];
    assign o_ok    = r_ok[FW];
    assign o_tq    = r_tq[FW];
    assign o_sx    = r_sx[FW];
    assign o_sy    = r_sy[FW];
    assign o_wx    = r_wx[FW];
    assign o_wy    = r_wy[FW];

endmodule

`default_nettype wire

FILE: sv/rsi_lerp.sv
// ----------------------------------------------------------------------------
// rsi_lerp
// Hit decision and interpolation S + t*(E - S), product truncated toward
// zero. Three register stages, the last one is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_lerp #(
    parameter int CW = 32,
    parameter int FW = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_ok,
    input  wire logic [FW-1:0]        i_tq,
    input  wire logic signed [CW-1:0] i_sx,
    input  wire logic signed [CW-1:0] i_sy,
    input  wire logic signed [CW:0]   i_wx,
    input  wire logic signed [CW:0]   i_wy,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic                      o_hit,
    output logic signed [CW-1:0]      o_hit_x,
    output logic signed [CW-1:0]      o_hit_y
);
    import rsi_pkg::*;

    localparam int QW = FW + CW + 1;

    logic [3:1] r_v;
    logic [4:1] w_en;

    // stage 1
    logic                 r_hit1, r_negx1, r_negy1;
    logic [FW-1:0]        r_tq1;
    logic [CW:0]          r_magx1, r_magy1;
    logic signed [CW-1:0] r_sx1, r_sy1;
    // stage 2
    logic                 r_hit2, r_negx2, r_negy2;
    logic [QW-1:0]        r_prodx, r_prody;
    logic signed [CW-1:0] r_sx2, r_sy2;
    // stage 3
    logic                 r_hit3;
    logic signed [CW-1:0] r_hx, r_hy;

    logic [CW-1:0] w_mx, w_my;
    logic [CW-1:0] n_hx, n_hy;

    assign w_en[4] = i_ready;
    genvar g;
    generate
        for (g = 1; g <= 3; g++) begin : g_en
            assign w_en[g] = !r_v[g] || w_en[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_valid;
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
        end
    end

    // stage 1: E - S = -W; keep its magnitude and sign
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_hit1  <= i_ok && (i_tq != '0);
            r_tq1   <= i_tq;
            r_negx1 <= !i_wx[CW] && (i_wx != '0);
            r_negy1 <= !i_wy[CW] && (i_wy != '0);
            r_magx1 <= i_wx[CW] ? (~i_wx + 1'b1) : i_wx;
            r_magy1 <= i_wy[CW] ? (~i_wy + 1'b1) : i_wy;
            r_sx1   <= i_sx;
            r_sy1   <= i_sy;
        end
    end

    // stage 2: unsigned t * |E - S|
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_hit2  <= r_hit1;
            r_negx2 <= r_negx1;
            r_negy2 <= r_negy1;
            r_prodx <= QW'(r_tq1) * QW'(r_magx1);
            r_prody <= QW'(r_tq1) * QW'(r_magy1);
            r_sx2   <= r_sx1;
            r_sy2   <= r_sy1;
        end
    end

    // stage 3: drop fraction, restore sign, add start; wraps at CW bits
    always_comb begin
        w_mx = r_prodx[FW +: CW];
        w_my = r_prody[FW +: CW];
        n_hx = r_sx2 + (r_negx2 ? (~w_mx + 1'b1) : w_mx);
        n_hy = r_sy2 + (r_negy2 ? (~w_my + 1'b1) : w_my);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_hit3 <= r_hit2;
            r_hx   <= r_hit2 ? n_hx : '0;
            r_hy   <= r_hit2 ? n_hy : '0;
        end
    end

    assign o_ready = w_en[1];
    assign o_valid = r_v[3];
    assign o_hit   = r_hit3;
    assign o_hit_x = r_hx;
    assign o_hit_y = r_hy;

endmodule

`default_nettype wire

FILE: sv/ray_segment_intersection.sv
// Divider: one stage per quotient bit; signed Q16.16 coordinates by default.
// Throughput: one item per cycle while the output is not stalled.
// Each stage advances when it is empty or the next one advances, so bubbles fill
// while a result waits at the output.
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// ray_segment_intersection
// 2D ray against wall segment test in signed fixed point, giving the hit flag
// and the intersection point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_segment_intersection #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_ray_dx,
    input  wire logic signed [COORD_WIDTH-1:0] i_ray_dy,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_start_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_start_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_end_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_wall_end_y,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_hit,
    output logic signed [COORD_WIDTH-1:0]      o_hit_x,
    output logic signed [COORD_WIDTH-1:0]      o_hit_y
);
    import rsi_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int FW = FRAC_BITS;

    logic                 w_c_valid, w_c_ready, w_c_ok;
    logic [2*CW:0]        w_c_dm, w_c_tm;
    logic signed [CW-1:0] w_c_sx, w_c_sy;
    logic signed [CW:0]   w_c_wx, w_c_wy;

    logic                 w_d_valid, w_d_ready, w_d_ok;
    logic [FW-1:0]        w_d_tq;
    logic signed [CW-1:0] w_d_sx, w_d_sy;
    logic signed [CW:0]   w_d_wx, w_d_wy;

    rsi_cross #(.CW(CW)) u_cross (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_ray_dx       (i_ray_dx),
        .i_ray_dy       (i_ray_dy),
        .i_wall_start_x (i_wall_start_x),
        .i_wall_start_y (i_wall_start_y),
        .i_wall_end_x   (i_wall_end_x),
        .i_wall_end_y   (i_wall_end_y),
        .o_valid        (w_c_valid),
        .i_ready        (w_c_ready),
        .o_ok           (w_c_ok),
        .o_dm           (w_c_dm),
        .o_tm           (w_c_tm),
        .o_sx           (w_c_sx),
        .o_sy           (w_c_sy),
        .o_wx           (w_c_wx),
        .o_wy           (w_c_wy)
    );

    rsi_div #(.CW(CW), .FW(FW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .o_ready (w_c_ready),
        .i_ok    (w_c_ok),
        .i_dm    (w_c_dm),
        .i_tm    (w_c_tm),
        .i_sx    (w_c_sx),
        .i_sy    (w_c_sy),
        .i_wx    (w_c_wx),
        .i_wy    (w_c_wy),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_ok    (w_d_ok),
        .o_tq    (w_d_tq),
        .o_sx    (w_d_sx),
        .o_sy    (w_d_sy),
        .o_wx    (w_d_wx),
        .o_wy    (w_d_wy)
    );

    rsi_lerp #(.CW(CW), .FW(FW)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .o_ready (w_d_ready),
        .i_ok    (w_d_ok),
        .i_tq    (w_d_tq),
        .i_sx    (w_d_sx),
        .i_sy    (w_d_sy),
        .i_wx    (w_d_wx),
        .i_wy    (w_d_wy),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_hit   (o_hit),
        .o_hit_x (o_hit_x),
        .o_hit_y (o_hit_y)
    );

endmodule

`default_nettype wire

FILE: sv/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker
// Port-level checks for the intersection pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsi_checker #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_valid,
    input wire logic                   o_ready,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic                   o_hit,
    input wire logic [COORD_WIDTH-1:0] o_hit_x,
    input wire logic [COORD_WIDTH-1:0] o_hit_y
);
    import rsi_pkg::*;

    localparam int DEPTH = FRAC_BITS + FIXED_STAGES;
    localparam int CNTW  = $clog2(DEPTH + 2);

    logic            w_in_acc, w_out_acc;
    logic [CNTW-1:0] r_inflight;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;

    // items inside the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_inflight <= r_inflight + 1'b1;
        end else if (!w_in_acc && w_out_acc) begin
            r_inflight <= r_inflight - 1'b1;
        end
    end

    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> (r_inflight != '0))
        else $error("result item without an accepted input item");

    a_depth : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNTW'(DEPTH))
        else $error("more items in flight than pipeline stages");

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_x == '0 && o_hit_y == '0))
        else $error("miss with nonzero intersection point");

    a_empty_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output is empty");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_hit) && $stable(o_hit_x)
            && $stable(o_hit_y)))
        else $error("stalled result item changed");

endmodule

bind ray_segment_intersection rsi_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
) u_rsi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_hit   (o_hit),
    .o_hit_x (o_hit_x),
    .o_hit_y (o_hit_y)
);

`default_nettype wire
